// ===== hdl/nirsd_pkg.sv =====
// nirsd_pkg: shared types, constants and duration-window helpers of the ir frame decoder
package nirsd_pkg;

    // duration field width and derived arithmetic widths
    localparam int DurBits   = 15;
    localparam int Percent   = 100;
    localparam int ScaledW   = DurBits + 7;
    localparam int BoundW    = 21;
    localparam int CmpW      = (ScaledW > BoundW) ? ScaledW : BoundW;
    localparam int TolW      = 6;
    localparam int FactorW   = 8;
    localparam int IdxW      = 6;
    localparam int HalfW     = 16;
    localparam int BitCount  = 2 * HalfW;
    localparam int PosW      = $clog2(BitCount);

    // nominal durations in microseconds
    localparam int LeadMark  = 9000;
    localparam int LeadSpace = 4500;
    localparam int RepSpace  = 2250;
    localparam int BitMark   = 560;
    localparam int ZeroSpace = 560;
    localparam int OneSpace  = 1690;

    // capture lengths
    localparam int FrameLen  = 34;
    localparam int RepeatLen = 2;
    localparam int IndexSat  = 35;

    localparam logic [TolW-1:0] TolReset = TolW'(15);

    typedef struct packed {
        logic [DurBits-1:0] mark_time;
        logic [DurBits-1:0] space_time;
        logic               last_symbol;
    } t_in_item;

    typedef struct packed {
        logic [HalfW-1:0] address;
        logic [HalfW-1:0] command;
        logic             repeat_res;
    } t_out_item;

    // scaled acceptance window of one nominal duration
    typedef struct packed {
        logic [BoundW-1:0] lo;
        logic [BoundW-1:0] hi;
    } t_range;

    typedef struct packed {
        t_range lead_mark;
        t_range lead_space;
        t_range rep_space;
        t_range bit_mark;
        t_range one_space;
    } t_bounds;

    // per-symbol verdicts
    typedef struct packed {
        logic lead_ok;
        logic repeat_ok;
        logic bit_one;
        logic bit_zero;
    } t_sym_class;

    function automatic t_range window(input int nominal, input logic [TolW-1:0] tol);
        logic [FactorW-1:0] lo_f;
        logic [FactorW-1:0] hi_f;
        t_range             r;
        lo_f = FactorW'(Percent) - FactorW'(tol);
        hi_f = FactorW'(Percent) + FactorW'(tol);
        r.lo = BoundW'(nominal) * BoundW'(lo_f);
        r.hi = BoundW'(nominal) * BoundW'(hi_f);
        return r;
    endfunction

    function automatic t_bounds bounds_for(input logic [TolW-1:0] tol);
        t_bounds b;
        b.lead_mark  = window(LeadMark, tol);
        b.lead_space = window(LeadSpace, tol);
        b.rep_space  = window(RepSpace, tol);
        b.bit_mark   = window(BitMark, tol);
        b.one_space  = window(OneSpace, tol);
        return b;
    endfunction

    function automatic logic [CmpW-1:0] scale_dur(input logic [DurBits-1:0] d);
        return CmpW'(d) * CmpW'(Percent);
    endfunction

    function automatic logic in_window(input logic [CmpW-1:0] s, input t_range r);
        return (s >= CmpW'(r.lo)) && (s <= CmpW'(r.hi));
    endfunction

endpackage

// ===== hdl/nec_ir_symbol_frame_decoder.sv =====
// nec_ir_symbol_frame_decoder: top level of the nec infrared symbol frame decoder
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_stall  o_out_item (t_out_item)
//   cfg       input      i_cfg_we                   i_cfg_wdata (tolerance, percent)
//
// one item per cycle sustained while the output is not stalled; an item waits in the input register and
// its result, if any, is loaded into the result register when the item leaves it.
// the throughput is set by the single-pass window compare between the two registers.
// reset is synchronous and active low; tolerance returns to 15 percent.
// an output stall holds the result register and back-pressures the input register;
// a new item is still taken while the input register is empty.
module nec_ir_symbol_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nirsd_pkg::TolW-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  nirsd_pkg::t_in_item           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output nirsd_pkg::t_out_item          o_out_item
);

    logic                   r_in_valid;
    logic                   n_in_valid;
    nirsd_pkg::t_in_item    r_in_item;
    nirsd_pkg::t_bounds     bounds;
    nirsd_pkg::t_sym_class  sym_class;
    logic                   out_free;
    logic                   accept;
    logic                   fire;

    // input register handshake
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_in_valid = accept || (r_in_valid && !fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_item;
        end
    end

    nirsd_bounds u_bounds (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_bounds    (bounds)
    );

    nirsd_sym_class u_sym_class (
        .i_item   (r_in_item),
        .i_bounds (bounds),
        .o_class  (sym_class)
    );

    nirsd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_last      (r_in_item.last_symbol),
        .i_class     (sym_class),
        .i_out_stall (i_out_stall),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hdl/nirsd_bounds.sv =====
// nirsd_bounds: tolerance register held as precomputed duration windows
module nirsd_bounds (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nirsd_pkg::TolW-1:0]   i_cfg_wdata,
    output nirsd_pkg::t_bounds           o_bounds
);

    nirsd_pkg::t_bounds r_bounds;
    nirsd_pkg::t_bounds n_bounds;

    // windows follow the written tolerance
    always_comb begin
        n_bounds = r_bounds;
        if (i_cfg_we) begin
            n_bounds = nirsd_pkg::bounds_for(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds <= nirsd_pkg::bounds_for(nirsd_pkg::TolReset);
        end else begin
            r_bounds <= n_bounds;
        end
    end

    assign o_bounds = r_bounds;

endmodule

// ===== hdl/nirsd_sym_class.sv =====
// nirsd_sym_class: judges one symbol against the leader, repeat and bit windows
module nirsd_sym_class (
    input  nirsd_pkg::t_in_item    i_item,
    input  nirsd_pkg::t_bounds     i_bounds,
    output nirsd_pkg::t_sym_class  o_class
);

    logic [nirsd_pkg::DurBits-1:0] space_eff;
    logic [nirsd_pkg::CmpW-1:0]    mark_s;
    logic [nirsd_pkg::CmpW-1:0]    space_s;
    logic [nirsd_pkg::CmpW-1:0]    space_eff_s;
    logic                          mark_bit;

    // a missing space in a bit symbol stands for a short space
    assign space_eff = (i_item.space_time == '0) ?
                       nirsd_pkg::DurBits'(nirsd_pkg::ZeroSpace) : i_item.space_time;

    assign mark_s      = nirsd_pkg::scale_dur(i_item.mark_time);
    assign space_s     = nirsd_pkg::scale_dur(i_item.space_time);
    assign space_eff_s = nirsd_pkg::scale_dur(space_eff);

    assign mark_bit = nirsd_pkg::in_window(mark_s, i_bounds.bit_mark);

    // leader checks use the raw space
    assign o_class.lead_ok   = nirsd_pkg::in_window(mark_s, i_bounds.lead_mark) &&
                               nirsd_pkg::in_window(space_s, i_bounds.lead_space);
    assign o_class.repeat_ok = nirsd_pkg::in_window(mark_s, i_bounds.lead_mark) &&
                               nirsd_pkg::in_window(space_s, i_bounds.rep_space);
    // zero space shares the bit mark window
    assign o_class.bit_one   = mark_bit &&
                               nirsd_pkg::in_window(space_eff_s, i_bounds.one_space);
    assign o_class.bit_zero  = mark_bit &&
                               nirsd_pkg::in_window(space_eff_s, i_bounds.bit_mark);

endmodule

// ===== hdl/nirsd_frame.sv =====
// nirsd_frame: capture state, held frame and result register
module nirsd_frame (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic                   i_last,
    input  nirsd_pkg::t_sym_class  i_class,
    input  logic                   i_out_stall,
    output logic                   o_out_free,
    output logic                   o_out_valid,
    output nirsd_pkg::t_out_item   o_out_item
);

    logic [nirsd_pkg::IdxW-1:0]     r_idx;
    logic [nirsd_pkg::IdxW-1:0]     n_idx;
    logic [nirsd_pkg::BitCount-1:0] r_shift;
    logic [nirsd_pkg::BitCount-1:0] n_shift;
    logic                           r_good;
    logic                           n_good;
    logic                           r_rep;
    logic                           n_rep;
    logic [nirsd_pkg::HalfW-1:0]    r_held_addr;
    logic [nirsd_pkg::HalfW-1:0]    n_held_addr;
    logic [nirsd_pkg::HalfW-1:0]    r_held_cmd;
    logic [nirsd_pkg::HalfW-1:0]    n_held_cmd;
    logic                           r_out_valid;
    logic                           n_out_valid;
    nirsd_pkg::t_out_item           r_out;
    nirsd_pkg::t_out_item           n_out;

    logic [nirsd_pkg::IdxW-1:0]     count;
    logic [nirsd_pkg::PosW-1:0]     pos;
    logic                           emit_frame;
    logic                           emit_rep;

    assign o_out_free = !r_out_valid || !i_out_stall;
    assign pos        = nirsd_pkg::PosW'(r_idx - nirsd_pkg::IdxW'(1));
    assign count      = (r_idx < nirsd_pkg::IdxW'(nirsd_pkg::IndexSat)) ?
                        r_idx + nirsd_pkg::IdxW'(1) : nirsd_pkg::IdxW'(nirsd_pkg::IndexSat);

    // symbol update, end-of-capture judgement and result load
    always_comb begin
        n_idx       = r_idx;
        n_shift     = r_shift;
        n_good      = r_good;
        n_rep       = r_rep;
        n_held_addr = r_held_addr;
        n_held_cmd  = r_held_cmd;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        emit_frame  = 1'b0;
        emit_rep    = 1'b0;
        if (i_fire) begin
            if (r_idx == '0) begin
                n_good = i_class.lead_ok;
                n_rep  = i_class.repeat_ok;
            end else if (r_idx <= nirsd_pkg::IdxW'(nirsd_pkg::BitCount)) begin
                if (i_class.bit_one) begin
                    n_shift[pos] = 1'b1;
                end else if (!i_class.bit_zero) begin
                    n_good = 1'b0;
                end
            end
            if (!i_last) begin
                n_idx = count;
            end else begin
                emit_frame = (count == nirsd_pkg::IdxW'(nirsd_pkg::FrameLen)) && n_good;
                emit_rep   = !emit_frame &&
                             (count == nirsd_pkg::IdxW'(nirsd_pkg::RepeatLen)) && n_rep;
                if (emit_frame) begin
                    n_held_addr = n_shift[nirsd_pkg::HalfW-1:0];
                    n_held_cmd  = n_shift[nirsd_pkg::BitCount-1:nirsd_pkg::HalfW];
                end
                if (emit_frame || emit_rep) begin
                    n_out.address    = n_held_addr;
                    n_out.command    = n_held_cmd;
                    n_out.repeat_res = emit_rep;
                    n_out_valid      = 1'b1;
                end
                n_idx   = '0;
                n_shift = '0;
                n_good  = 1'b1;
                n_rep   = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_shift     <= '0;
            r_good      <= 1'b1;
            r_rep       <= 1'b0;
            r_held_addr <= '0;
            r_held_cmd  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_shift     <= n_shift;
            r_good      <= n_good;
            r_rep       <= n_rep;
            r_held_addr <= n_held_addr;
            r_held_cmd  <= n_held_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // index stays within its saturation limit
    a_idx_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= nirsd_pkg::IdxW'(nirsd_pkg::IndexSat))
        else $error("symbol index beyond saturation");

    // the end of a capture always restarts the index
    a_idx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |=> r_idx == '0)
        else $error("index not cleared after last symbol");

    // a waiting result always carries the held frame
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.address == r_held_addr) && (r_out.command == r_held_cmd))
        else $error("result differs from held frame");

    // a new result only appears after a last symbol
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_fire && i_last))
        else $error("result without end of capture");
`endif

endmodule

// ===== test/nec_ir_symbol_frame_decoder_test.sv =====
// nec_ir_symbol_frame_decoder_test: self-checking testbench of the nec ir symbol frame decoder
`timescale 1ns / 1ps

module nec_ir_symbol_frame_decoder_test;

    typedef nirsd_pkg::t_in_item t_capture[$];

    // ways of breaking a well-formed capture
    typedef enum int {
        SpoilReplace,
        SpoilDrop,
        SpoilInsert,
        SpoilExtend,
        SpoilNudge
    } t_spoil;

    localparam int ClkHalf      = 6;
    localparam int QuietLimit   = 2000;
    localparam int HoldCycles   = 300;
    localparam int SettleCycles = 4;
    localparam int TailCycles   = 8;
    localparam int MaxDur       = (1 << nirsd_pkg::DurBits) - 1;
    localparam int PhaseItems   = 300;
    localparam int MaxNoiseLen  = 40;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [nirsd_pkg::TolW-1:0]     i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    nirsd_pkg::t_in_item            i_in_item;
    logic                           o_out_valid;
    logic                           i_out_stall;
    nirsd_pkg::t_out_item           o_out_item;

    // mirror of the decoder state
    int unsigned                    sym_pos;
    logic [nirsd_pkg::BitCount-1:0] collected_bits;
    bit                             capture_ok;
    bit                             repeat_lead;
    logic [nirsd_pkg::HalfW-1:0]    held_addr;
    logic [nirsd_pkg::HalfW-1:0]    held_cmd;
    logic [nirsd_pkg::TolW-1:0]     tol_pct;
    nirsd_pkg::t_out_item           expected_codes[$];

    int err_count    = 0;
    int sent_items   = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_len     = 0;
    int cur_tol      = int'(nirsd_pkg::TolReset);
    int quiet_cycles = 0;

    nec_ir_symbol_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // clock
    initial i_clk = 1'b0;
    always #(ClkHalf) i_clk = ~i_clk;

    // exact integer tolerance window of one nominal duration
    function automatic bit within_tol(input int unsigned dur, input int unsigned nominal);
        int unsigned tol;
        int unsigned scaled;
        tol    = tol_pct;
        scaled = dur * nirsd_pkg::Percent;
        return scaled >= nominal * (nirsd_pkg::Percent - tol) &&
               scaled <= nominal * (nirsd_pkg::Percent + tol);
    endfunction

    function automatic void clear_capture();
        sym_pos        = 0;
        collected_bits = '0;
        capture_ok     = 1'b1;
        repeat_lead    = 1'b0;
    endfunction

    // one symbol into the capture; at its end, the code it yields if any
    function automatic void decode_symbol(input nirsd_pkg::t_in_item it, output bit emit,
                                          output nirsd_pkg::t_out_item code);
        int unsigned idx;
        int unsigned count;
        int unsigned spc;
        bit          mark_ok;
        idx  = sym_pos;
        emit = 1'b0;
        code = '0;
        if (idx == 0) begin
            mark_ok     = within_tol(it.mark_time, nirsd_pkg::LeadMark);
            capture_ok  = mark_ok && within_tol(it.space_time, nirsd_pkg::LeadSpace);
            repeat_lead = mark_ok && within_tol(it.space_time, nirsd_pkg::RepSpace);
        end else if (idx <= nirsd_pkg::BitCount) begin
            // a space that was not captured counts as a short one
            spc     = (it.space_time == 0) ? nirsd_pkg::ZeroSpace : it.space_time;
            mark_ok = within_tol(it.mark_time, nirsd_pkg::BitMark);
            if (mark_ok && within_tol(spc, nirsd_pkg::OneSpace)) begin
                collected_bits[idx-1] = 1'b1;
            end else if (!(mark_ok && within_tol(spc, nirsd_pkg::ZeroSpace))) begin
                capture_ok = 1'b0;
            end
        end
        count = (idx < nirsd_pkg::IndexSat) ? idx + 1 : nirsd_pkg::IndexSat;
        if (!it.last_symbol) begin
            sym_pos = count;
            return;
        end
        if (count == nirsd_pkg::FrameLen && capture_ok) begin
            held_addr = collected_bits[nirsd_pkg::HalfW-1:0];
            held_cmd  = collected_bits[nirsd_pkg::BitCount-1:nirsd_pkg::HalfW];
            code      = '{address: held_addr, command: held_cmd, repeat_res: 1'b0};
            emit      = 1'b1;
        end else if (count == nirsd_pkg::RepeatLen && repeat_lead) begin
            code = '{address: held_addr, command: held_cmd, repeat_res: 1'b1};
            emit = 1'b1;
        end
        clear_capture();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // result checking and prediction of accepted items
    always @(posedge i_clk) begin : scoreboard
        bit                   emit;
        nirsd_pkg::t_out_item code;
        nirsd_pkg::t_out_item want;
        if (!i_rst_n) begin
            tol_pct   = nirsd_pkg::TolReset;
            held_addr = '0;
            held_cmd  = '0;
            clear_capture();
            expected_codes.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("result with nothing expected", o_out_item.address, 0);
                end else begin
                    want = expected_codes.pop_front();
                    if (o_out_item.address !== want.address)
                        report_mismatch("address", o_out_item.address, want.address);
                    if (o_out_item.command !== want.command)
                        report_mismatch("command", o_out_item.command, want.command);
                    if (o_out_item.repeat_res !== want.repeat_res)
                        report_mismatch("repeat flag", o_out_item.repeat_res, want.repeat_res);
                end
            end
            if (i_cfg_we) tol_pct = i_cfg_wdata;
            if (i_in_valid && !o_in_stall) begin
                decode_symbol(i_in_item, emit, code);
                if (emit) expected_codes.push_back(code);
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result receiver: random stalls, or one long hold-off on request
    initial begin : receiver
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(negedge i_clk);
                hold_len = 0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic nirsd_pkg::t_in_item symbol(input int mark, input int space,
                                                   input bit last);
        nirsd_pkg::t_in_item s;
        s.mark_time   = mark[nirsd_pkg::DurBits-1:0];
        s.space_time  = space[nirsd_pkg::DurBits-1:0];
        s.last_symbol = last;
        return s;
    endfunction

    // a duration anywhere inside the current window
    function automatic int jittered(input int nominal);
        int r;
        r = int'($urandom_range(0, 2 * cur_tol)) - cur_tol;
        return nominal + nominal * r / nirsd_pkg::Percent;
    endfunction

    // first or last duration inside the window, or one step beyond it
    function automatic int window_edge(input int nominal, input bit upper, input bit outside);
        int lim;
        if (upper) begin
            lim = nominal * (nirsd_pkg::Percent + cur_tol) / nirsd_pkg::Percent;
            return outside ? lim + 1 : lim;
        end
        lim = (nominal * (nirsd_pkg::Percent - cur_tol) + nirsd_pkg::Percent - 1) /
              nirsd_pkg::Percent;
        return outside ? lim - 1 : lim;
    endfunction

    function automatic int pick_dur(input int nominal, input bit at_edges);
        return at_edges ? window_edge(nominal, 1'($urandom_range(0, 1)), 1'b0)
                        : jittered(nominal);
    endfunction

    // leader, 32 data symbols lsb first and a trailing symbol
    function automatic t_capture frame_capture(input logic [nirsd_pkg::HalfW-1:0] addr,
                                               input logic [nirsd_pkg::HalfW-1:0] cmd,
                                               input bit at_edges);
        t_capture                       c;
        logic [nirsd_pkg::BitCount-1:0] word;
        int                             sp;
        word = {cmd, addr};
        c.push_back(symbol(pick_dur(nirsd_pkg::LeadMark, at_edges),
                           pick_dur(nirsd_pkg::LeadSpace, at_edges), 1'b0));
        for (int i = 0; i < nirsd_pkg::BitCount; i++) begin
            if (word[i]) begin
                sp = pick_dur(nirsd_pkg::OneSpace, at_edges);
            end else if ($urandom_range(0, 3) == 0) begin
                sp = 0;
            end else begin
                sp = pick_dur(nirsd_pkg::ZeroSpace, at_edges);
            end
            c.push_back(symbol(pick_dur(nirsd_pkg::BitMark, at_edges), sp, 1'b0));
        end
        c.push_back(symbol(pick_dur(nirsd_pkg::BitMark, at_edges),
                           $urandom_range(0, MaxDur), 1'b1));
        return c;
    endfunction

    function automatic t_capture repeat_capture();
        t_capture c;
        c.push_back(symbol(jittered(nirsd_pkg::LeadMark), jittered(nirsd_pkg::RepSpace), 1'b0));
        c.push_back(symbol(jittered(nirsd_pkg::BitMark), 0, 1'b1));
        return c;
    endfunction

    // random length, mostly random durations
    function automatic t_capture noise_capture();
        t_capture c;
        int       len;
        int       mark;
        int       space;
        len = $urandom_range(1, MaxNoiseLen);
        for (int i = 0; i < len; i++) begin
            mark  = $urandom_range(0, 1) ? $urandom_range(0, MaxDur)
                                         : jittered(nirsd_pkg::BitMark);
            space = $urandom_range(0, 1) ? $urandom_range(0, MaxDur)
                                         : jittered(nirsd_pkg::OneSpace);
            c.push_back(symbol(mark, space, i == len - 1));
        end
        return c;
    endfunction

    function automatic void spoil(ref t_capture c, input t_spoil kind);
        int                  pos;
        int                  extra;
        nirsd_pkg::t_in_item s;
        pos = $urandom_range(0, c.size() - 1);
        case (kind)
            SpoilReplace: begin
                c[pos] = symbol($urandom_range(0, MaxDur), $urandom_range(0, MaxDur), 1'b0);
            end
            SpoilDrop: begin
                c.delete(pos);
            end
            SpoilInsert: begin
                c.insert(pos, symbol(jittered(nirsd_pkg::BitMark),
                                     jittered(nirsd_pkg::OneSpace), 1'b0));
            end
            SpoilExtend: begin
                // on a frame capture, long enough to reach the saturated index
                extra = $urandom_range(1, 6);
                repeat (extra) c.push_back(symbol(jittered(nirsd_pkg::BitMark),
                                                  jittered(nirsd_pkg::ZeroSpace), 1'b0));
            end
            default: begin
                s = c[pos];
                s.mark_time = nirsd_pkg::DurBits'(window_edge(
                    pos == 0 ? nirsd_pkg::LeadMark : nirsd_pkg::BitMark,
                    1'($urandom_range(0, 1)), 1'b1));
                c[pos] = s;
            end
        endcase
        // exactly one end marker, on the final symbol
        foreach (c[i]) c[i].last_symbol = (i == c.size() - 1);
    endfunction

    // offer one item and hold it until taken; returns at the next falling edge
    task automatic send_symbol(input nirsd_pkg::t_in_item it);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_capture(input t_capture c);
        foreach (c[i]) send_symbol(c[i]);
    endtask

    // sender stops until every expected code is out and the pipeline has emptied
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_codes.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input int tol);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= nirsd_pkg::TolW'(tol);
        cur_tol = tol;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // repeat code before any frame gives the reset address and command
    task automatic test_repeat_after_reset();
        send_capture(repeat_capture());
    endtask

    task automatic test_field_extremes();
        t_capture c;
        c = '{symbol(MaxDur, MaxDur, 1'b0), symbol(0, 0, 1'b1)};
        send_capture(c);
        c = '{symbol(MaxDur, 0, 1'b1)};
        send_capture(c);
        c = '{symbol(0, MaxDur, 1'b1)};
        send_capture(c);
        // leader without a captured space: no short-space substitution here
        c = '{symbol(nirsd_pkg::LeadMark, 0, 1'b0), symbol(nirsd_pkg::BitMark, 0, 1'b1)};
        send_capture(c);
    endtask

    task automatic test_frame_then_repeat();
        send_capture(frame_capture(16'hFFFF, 16'h0000, 1'b0));
        send_capture(repeat_capture());
    endtask

    // window edges at several tolerances, including zero and the field maximum
    task automatic test_tolerance_settings();
        int       settings[5] = '{0, 50, 63, 1, 15};
        t_capture c;
        foreach (settings[k]) begin
            write_tolerance(settings[k]);
            send_capture(frame_capture(16'($urandom), 16'($urandom), 1'b1));
            c = frame_capture(16'($urandom), 16'($urandom), 1'b1);
            spoil(c, SpoilNudge);
            send_capture(c);
            send_capture(repeat_capture());
        end
    endtask

    // mostly well-formed captures with random content, the rest broken or noise
    task automatic test_traffic(input int idle, input int stall, input int tol, input int n);
        int       stop_at;
        int       pick;
        t_capture c;
        write_tolerance(tol);
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = sent_items + n;
        while (sent_items < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                c = frame_capture(16'($urandom), 16'($urandom), $urandom_range(0, 9) == 0);
            end else if (pick < 72) begin
                c = repeat_capture();
            end else if (pick < 90) begin
                if (pick < 84) c = frame_capture(16'($urandom), 16'($urandom), 1'b0);
                else c = repeat_capture();
                spoil(c, t_spoil'($urandom_range(0, 4)));
            end else begin
                c = noise_capture();
            end
            send_capture(c);
        end
    endtask

    // long output hold-off while items keep coming, then a full drain
    task automatic test_output_hold();
        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();
        hold_len = HoldCycles;
        repeat (3) begin
            send_capture(frame_capture(16'($urandom), 16'($urandom), 1'b0));
            send_capture(repeat_capture());
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_repeat_after_reset();
        test_field_extremes();
        test_frame_then_repeat();
        test_tolerance_settings();
        test_traffic(0, 0, int'(nirsd_pkg::TolReset), PhaseItems);
        test_traffic(54, 0, $urandom_range(5, 40), PhaseItems);
        test_traffic(0, 54, $urandom_range(5, 40), PhaseItems);
        test_traffic(25, 25, $urandom_range(5, 40), PhaseItems);
        test_output_hold();

        // trailing window for late or spurious results
        wait_drained();
        repeat (TailCycles) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
